### rtl/jsu_pkg.sv
package jsu_pkg;

  // default depth of the command queue between front and back
  localparam int unsigned JSU_CMD_DEPTH = 4;

  // characters the decoder reacts to
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // error numbers
  typedef enum logic [2:0] {
    ERR_EXPECT_QUOTE  = 3'd0,
    ERR_UNTERM_ESCAPE = 3'd1,
    ERR_BAD_UNICODE   = 3'd2,
    ERR_BAD_SURROGATE = 3'd3,
    ERR_UNSUPPORTED   = 3'd4,
    ERR_UNTERM_STRING = 3'd5
  } err_e;

  // input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] err_num;
    logic       last;
  } out_item_t;

  // work for the back end: an optional code point, then an optional single result
  typedef struct packed {
    logic        cp_v;
    logic [20:0] cp;
    logic        tail_v;
    kind_e       tail_kind;
    logic [7:0]  tail_byte;
    err_e        tail_err;
  } cmd_t;

endpackage

### rtl/jsu_front.sv
module jsu_front import jsu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     cmd_v_o,
  output cmd_t     cmd_o
);

  typedef enum logic [6:0] {
    ST_WAIT    = 7'b0000001,
    ST_BODY    = 7'b0000010,
    ST_ESC     = 7'b0000100,
    ST_HEX     = 7'b0001000,
    ST_HIGH    = 7'b0010000,
    ST_HIGH_BS = 7'b0100000,
    ST_LOW_HEX = 7'b1000000
  } state_e;

  // outcome of one string byte or one escape character
  typedef struct packed {
    state_e     mode;
    logic       tail_v;
    kind_e      kind;
    logic [7:0] data;
    err_e       err;
    logic       start_hex;
  } act_t;

  state_e      state_q, state_d;
  logic [15:0] accum_q, accum_d;
  logic [1:0]  count_q, count_d;
  logic [9:0]  high_q, high_d;

  logic [7:0]  c;
  logic        text_end;
  act_t        body_act, esc_act;
  logic        hex_v;
  logic [3:0]  hex_val;
  logic [15:0] accum_new;
  logic [20:0] high_cp;

  assign c        = item_i.in_byte;
  assign text_end = item_i.text_end;

  // hex digit decode
  always_comb begin
    hex_v   = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_v = 1'b0;
    end
  end

  assign accum_new = {accum_q[11:0], hex_val};
  // pending high surrogate as a code point
  assign high_cp   = {5'd0, 6'b110110, high_q};

  // plain string byte
  always_comb begin
    body_act           = '0;
    body_act.mode      = ST_BODY;
    body_act.tail_v    = 1'b1;
    body_act.kind      = KIND_DATA;
    body_act.data      = c;
    body_act.err       = ERR_EXPECT_QUOTE;
    body_act.start_hex = 1'b0;
    if (c == CH_QUOTE) begin
      body_act.mode = ST_WAIT;
      body_act.kind = KIND_CLOSE;
      body_act.data = 8'h00;
    end else if (c == CH_BSLASH) begin
      body_act.mode   = ST_ESC;
      body_act.tail_v = 1'b0;
    end
  end

  // character after a backslash
  always_comb begin
    esc_act           = '0;
    esc_act.mode      = ST_BODY;
    esc_act.tail_v    = 1'b1;
    esc_act.kind      = KIND_DATA;
    esc_act.data      = c;
    esc_act.err       = ERR_EXPECT_QUOTE;
    esc_act.start_hex = 1'b0;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: esc_act.data = c;
      CH_LOW_B: esc_act.data = 8'h08;
      CH_LOW_F: esc_act.data = 8'h0c;
      CH_LOW_N: esc_act.data = 8'h0a;
      CH_LOW_R: esc_act.data = 8'h0d;
      CH_LOW_T: esc_act.data = 8'h09;
      CH_LOW_U: begin
        esc_act.mode      = ST_HEX;
        esc_act.tail_v    = 1'b0;
        esc_act.start_hex = 1'b1;
      end
      default: begin
        esc_act.mode = ST_WAIT;
        esc_act.kind = KIND_ERROR;
        esc_act.data = 8'h00;
        esc_act.err  = ERR_UNSUPPORTED;
      end
    endcase
  end

  // decode state machine and command build
  always_comb begin
    state_d = state_q;
    accum_d = accum_q;
    count_d = count_q;
    high_d  = high_q;
    cmd_o   = '0;
    if (accept_i) begin
      case (state_q)
        ST_WAIT: begin
          if (!text_end && c == CH_QUOTE) begin
            state_d = ST_BODY;
          end else begin
            cmd_o.tail_v    = 1'b1;
            cmd_o.tail_kind = KIND_ERROR;
            cmd_o.tail_err  = ERR_EXPECT_QUOTE;
          end
        end
        ST_BODY: begin
          if (text_end) begin
            state_d         = ST_WAIT;
            cmd_o.tail_v    = 1'b1;
            cmd_o.tail_kind = KIND_ERROR;
            cmd_o.tail_err  = ERR_UNTERM_STRING;
          end else begin
            state_d         = body_act.mode;
            cmd_o.tail_v    = body_act.tail_v;
            cmd_o.tail_kind = body_act.kind;
            cmd_o.tail_byte = body_act.data;
            cmd_o.tail_err  = body_act.err;
          end
        end
        ST_ESC: begin
          if (text_end) begin
            state_d         = ST_WAIT;
            cmd_o.tail_v    = 1'b1;
            cmd_o.tail_kind = KIND_ERROR;
            cmd_o.tail_err  = ERR_UNTERM_ESCAPE;
          end else begin
            state_d         = esc_act.mode;
            cmd_o.tail_v    = esc_act.tail_v;
            cmd_o.tail_kind = esc_act.kind;
            cmd_o.tail_byte = esc_act.data;
            cmd_o.tail_err  = esc_act.err;
            if (esc_act.start_hex) begin
              accum_d = '0;
              count_d = '0;
            end
          end
        end
        ST_HEX, ST_LOW_HEX: begin
          if (text_end || !hex_v) begin
            state_d         = ST_WAIT;
            cmd_o.tail_v    = 1'b1;
            cmd_o.tail_kind = KIND_ERROR;
            cmd_o.tail_err  = (state_q == ST_HEX) ? ERR_BAD_UNICODE : ERR_BAD_SURROGATE;
          end else begin
            accum_d = accum_new;
            if (count_q != 2'd3) begin
              count_d = count_q + 2'd1;
            end else begin
              count_d = '0;
              if (state_q == ST_HEX) begin
                if (accum_new >= 16'hd800 && accum_new <= 16'hdbff) begin
                  high_d  = accum_new[9:0];
                  state_d = ST_HIGH;
                end else begin
                  state_d    = ST_BODY;
                  cmd_o.cp_v = 1'b1;
                  cmd_o.cp   = {5'd0, accum_new};
                end
              end else if (accum_new < 16'hdc00 || accum_new > 16'hdfff) begin
                state_d         = ST_WAIT;
                cmd_o.tail_v    = 1'b1;
                cmd_o.tail_kind = KIND_ERROR;
                cmd_o.tail_err  = ERR_BAD_SURROGATE;
              end else begin
                // low half in dc00..dfff: join the pair
                state_d    = ST_BODY;
                cmd_o.cp_v = 1'b1;
                cmd_o.cp   = 21'h10000 + {1'b0, high_q, accum_new[9:0]};
              end
            end
          end
        end
        ST_HIGH: begin
          if (!text_end && c == CH_BSLASH) begin
            state_d = ST_HIGH_BS;
          end else begin
            cmd_o.cp_v = 1'b1;
            cmd_o.cp   = high_cp;
            if (text_end) begin
              state_d         = ST_WAIT;
              cmd_o.tail_v    = 1'b1;
              cmd_o.tail_kind = KIND_ERROR;
              cmd_o.tail_err  = ERR_UNTERM_STRING;
            end else begin
              state_d         = body_act.mode;
              cmd_o.tail_v    = body_act.tail_v;
              cmd_o.tail_kind = body_act.kind;
              cmd_o.tail_byte = body_act.data;
              cmd_o.tail_err  = body_act.err;
            end
          end
        end
        ST_HIGH_BS: begin
          if (!text_end && c == CH_LOW_U) begin
            state_d = ST_LOW_HEX;
            accum_d = '0;
            count_d = '0;
          end else begin
            cmd_o.cp_v = 1'b1;
            cmd_o.cp   = high_cp;
            if (text_end) begin
              state_d         = ST_WAIT;
              cmd_o.tail_v    = 1'b1;
              cmd_o.tail_kind = KIND_ERROR;
              cmd_o.tail_err  = ERR_UNTERM_ESCAPE;
            end else begin
              state_d         = esc_act.mode;
              cmd_o.tail_v    = esc_act.tail_v;
              cmd_o.tail_kind = esc_act.kind;
              cmd_o.tail_byte = esc_act.data;
              cmd_o.tail_err  = esc_act.err;
              if (esc_act.start_hex) begin
                accum_d = '0;
                count_d = '0;
              end
            end
          end
        end
        default: begin
          state_d         = ST_WAIT;
          cmd_o.tail_v    = 1'b1;
          cmd_o.tail_kind = KIND_ERROR;
          cmd_o.tail_err  = ERR_EXPECT_QUOTE;
        end
      endcase
    end
  end

  assign cmd_v_o = cmd_o.cp_v | cmd_o.tail_v;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
      accum_q <= '0;
      count_q <= '0;
      high_q  <= '0;
    end else begin
      state_q <= state_d;
      accum_q <= accum_d;
      count_q <= count_d;
      high_q  <= high_d;
    end
  end

endmodule

### rtl/jsu_fifo.sv
module jsu_fifo import jsu_pkg::*; #(
  parameter int unsigned Depth = JSU_CMD_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t rdata_o,
  output logic empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + AW'(1);
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // fill count never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count beyond depth");

  // a write while full would be lost: the front must be held off
  a_no_lost_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o)) else $error("write into full queue");

  // pointers stay level when the queue is empty or full
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o || full_o) |-> (wptr_q == rptr_q)) else $error("queue pointers out of step");

endmodule

### rtl/jsu_back.sv
module jsu_back import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_empty_i,
  output logic      cmd_rd_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t item_o
);

  cmd_t        cur_q;
  logic        valid_q;
  logic [1:0]  idx_q;

  logic [2:0]  nb;
  logic [2:0]  total;
  logic [2:0]  idx_ext;
  logic        is_last;
  logic        advance, load;
  logic [1:0]  pos_from_end;
  logic [7:0]  utf8_byte;

  // number of utf-8 bytes for the held code point
  always_comb begin
    if (!cur_q.cp_v) begin
      nb = 3'd0;
    end else if (cur_q.cp <= 21'h7f) begin
      nb = 3'd1;
    end else if (cur_q.cp <= 21'h7ff) begin
      nb = 3'd2;
    end else if (cur_q.cp <= 21'hffff) begin
      nb = 3'd3;
    end else begin
      nb = 3'd4;
    end
  end

  assign total        = nb + {2'd0, cur_q.tail_v};
  assign idx_ext      = {1'b0, idx_q};
  assign is_last      = (idx_ext == total - 3'd1);
  assign pos_from_end = 2'(nb - 3'd1 - idx_ext);

  // utf-8 byte at the current position
  always_comb begin
    if (idx_q == 2'd0) begin
      case (nb)
        3'd1:    utf8_byte = cur_q.cp[7:0];
        3'd2:    utf8_byte = {3'b110, cur_q.cp[10:6]};
        3'd3:    utf8_byte = {4'b1110, cur_q.cp[15:12]};
        default: utf8_byte = {5'b11110, cur_q.cp[20:18]};
      endcase
    end else begin
      case (pos_from_end)
        2'd0:    utf8_byte = {2'b10, cur_q.cp[5:0]};
        2'd1:    utf8_byte = {2'b10, cur_q.cp[11:6]};
        default: utf8_byte = {2'b10, cur_q.cp[17:12]};
      endcase
    end
  end

  // result fields
  always_comb begin
    if (idx_ext < nb) begin
      item_o.kind     = KIND_DATA;
      item_o.out_byte = utf8_byte;
      item_o.err_num  = ERR_EXPECT_QUOTE;
    end else begin
      item_o.kind     = cur_q.tail_kind;
      item_o.out_byte = cur_q.tail_byte;
      item_o.err_num  = cur_q.tail_err;
    end
    item_o.last = is_last;
  end

  assign empty_o  = !valid_q;
  assign advance  = pop_i && valid_q;
  assign load     = !valid_q || (advance && is_last);
  assign cmd_rd_o = load && !cmd_empty_i;

  // payload of the held command
  always_ff @(posedge clk_i) begin
    if (cmd_rd_o) begin
      cur_q <= cmd_i;
    end
  end

  // sequencing through the results of one command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= !cmd_empty_i;
      idx_q   <= '0;
    end else if (advance) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  // the position never runs past the results of the held command
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_ext < total)) else $error("result index out of range");

  // a held result stays put while it is not taken
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !pop_i) |=> (valid_q && $stable(idx_q))) else $error("result dropped");

endmodule

### rtl/json_string_unescape_utf8.sv
// JSON string unescaper to UTF-8. Feed the bytes of a JSON text starting at the
// opening quote of a string; results come out as data bytes, a close marker or a
// numbered error, with last set on the final result caused by each input byte.
// One input byte is accepted every cycle while full is low. The back end hands
// out one result per cycle while pop is high, so a \u escape that expands into
// three or four UTF-8 bytes keeps it busy until all are taken; a command queue
// of CmdDepth entries between the decoder and the result sequencer absorbs
// those bursts, and full rises only when it fills. With queue and sequencer
// idle, a byte's first result is out once the sequencer has loaded its queued
// command. After a close or an error the decoder waits for a new opening quote.
module json_string_unescape_utf8 import jsu_pkg::*; #(
  parameter int unsigned CmdDepth = JSU_CMD_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic accept;
  logic cmd_v;
  cmd_t cmd_in, cmd_head;
  logic q_full, q_empty, q_rd;

  assign full   = q_full;
  assign accept = push && !q_full;

  // decoder
  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .cmd_v_o  (cmd_v),
    .cmd_o    (cmd_in)
  );

  // command queue
  jsu_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept && cmd_v),
    .wdata_i (cmd_in),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (cmd_head),
    .empty_o (q_empty)
  );

  // result sequencer
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (q_empty),
    .cmd_rd_o    (q_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .item_o      (out_item_o)
  );

endmodule

### dv/json_string_unescape_utf8_tb.sv
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  // decoder phases of the predictor
  typedef enum logic [2:0] {
    ST_WAIT,
    ST_BODY,
    ST_ESC,
    ST_HEX,
    ST_HIGH,
    ST_HIGH_BS,
    ST_LOW_HEX
  } dec_state_e;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item_i;
  logic      empty;
  logic      pop;
  out_item_t out_item_o;

  // predictor state
  dec_state_e  dec_state;
  logic [15:0] hex_acc;
  logic [1:0]  hex_cnt;
  logic [9:0]  high_bits;
  out_item_t   byte_results[$];
  out_item_t   utf8_expect_q[$];

  int error_count;
  int items_sent;
  int tx_max_wait;
  int rx_max_wait;

  json_string_unescape_utf8 u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // result builders
  function automatic void add_result(input out_item_t r);
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void put_data(input logic [7:0] b);
    add_result('{kind: KIND_DATA, out_byte: b, err_num: '0, last: 1'b0});
  endfunction

  function automatic void put_close();
    add_result('{kind: KIND_CLOSE, out_byte: '0, err_num: '0, last: 1'b0});
  endfunction

  function automatic void put_err(input err_e code);
    dec_state = ST_WAIT;
    add_result('{kind: KIND_ERROR, out_byte: '0, err_num: code, last: 1'b0});
  endfunction

  function automatic void put_utf8(input logic [20:0] cp);
    if (cp <= 21'h7f) begin
      put_data(cp[7:0]);
    end else if (cp <= 21'h7ff) begin
      put_data({3'b110, cp[10:6]});
      put_data({2'b10, cp[5:0]});
    end else if (cp <= 21'hffff) begin
      put_data({4'b1110, cp[15:12]});
      put_data({2'b10, cp[11:6]});
      put_data({2'b10, cp[5:0]});
    end else begin
      put_data({5'b11110, cp[20:18]});
      put_data({2'b10, cp[17:12]});
      put_data({2'b10, cp[11:6]});
      put_data({2'b10, cp[5:0]});
    end
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic void body_char(input logic [7:0] c);
    if (c == CH_QUOTE) begin
      dec_state = ST_WAIT;
      put_close();
    end else if (c == CH_BSLASH) begin
      dec_state = ST_ESC;
    end else begin
      dec_state = ST_BODY;
      put_data(c);
    end
  endfunction

  function automatic void escape_char(input logic [7:0] c);
    dec_state = ST_BODY;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: put_data(c);
      CH_LOW_B: put_data(8'h08);
      CH_LOW_F: put_data(8'h0c);
      CH_LOW_N: put_data(8'h0a);
      CH_LOW_R: put_data(8'h0d);
      CH_LOW_T: put_data(8'h09);
      CH_LOW_U: begin
        dec_state = ST_HEX;
        hex_acc   = '0;
        hex_cnt   = '0;
      end
      default: put_err(ERR_UNSUPPORTED);
    endcase
  endfunction

  // expected results of one accepted input item
  function automatic void predict_item(input in_item_t item);
    logic [7:0] c;
    logic       at_end;
    int         d;
    c      = item.in_byte;
    at_end = item.text_end;
    byte_results.delete();
    case (dec_state)
      ST_WAIT: begin
        if (!at_end && c == CH_QUOTE) dec_state = ST_BODY;
        else put_err(ERR_EXPECT_QUOTE);
      end
      ST_BODY: begin
        if (at_end) put_err(ERR_UNTERM_STRING);
        else body_char(c);
      end
      ST_ESC: begin
        if (at_end) put_err(ERR_UNTERM_ESCAPE);
        else escape_char(c);
      end
      ST_HEX, ST_LOW_HEX: begin
        d = at_end ? -1 : hex_nibble(c);
        if (d < 0) begin
          if (dec_state == ST_HEX) put_err(ERR_BAD_UNICODE);
          else put_err(ERR_BAD_SURROGATE);
        end else begin
          hex_acc = {hex_acc[11:0], d[3:0]};
          if (hex_cnt < 2'd3) begin
            hex_cnt = hex_cnt + 2'd1;
          end else begin
            hex_cnt = '0;
            if (dec_state == ST_HEX) begin
              if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
                high_bits = hex_acc[9:0];
                dec_state = ST_HIGH;
              end else begin
                dec_state = ST_BODY;
                put_utf8({5'b0, hex_acc});
              end
            end else if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
              put_err(ERR_BAD_SURROGATE);
            end else begin
              dec_state = ST_BODY;
              put_utf8(21'h10000 + {high_bits, hex_acc[9:0]});
            end
          end
        end
      end
      ST_HIGH: begin
        if (!at_end && c == CH_BSLASH) begin
          dec_state = ST_HIGH_BS;
        end else begin
          put_utf8({5'b0, 6'b110110, high_bits});
          if (at_end) put_err(ERR_UNTERM_STRING);
          else body_char(c);
        end
      end
      ST_HIGH_BS: begin
        if (!at_end && c == CH_LOW_U) begin
          dec_state = ST_LOW_HEX;
          hex_acc   = '0;
          hex_cnt   = '0;
        end else begin
          put_utf8({5'b0, 6'b110110, high_bits});
          if (at_end) put_err(ERR_UNTERM_ESCAPE);
          else escape_char(c);
        end
      end
      default: put_err(ERR_EXPECT_QUOTE);
    endcase
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[i]) utf8_expect_q.insert(utf8_expect_q.size(), byte_results[i]);
  endfunction

  // send one item, predict once it is taken
  task automatic send_item(input in_item_t item);
    int gap;
    gap = $urandom_range(0, tx_max_wait);
    repeat (gap) @(negedge clk_i) push <= 1'b0;
    @(negedge clk_i);
    push      <= 1'b1;
    in_item_i <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_item(item);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t item;
    item.in_byte  = b;
    item.text_end = 1'b0;
    send_item(item);
  endtask

  // byte field carries noise when the text ends
  task automatic send_end();
    in_item_t item;
    item.in_byte  = 8'($urandom_range(0, 255));
    item.text_end = 1'b1;
    send_item(item);
  endtask

  // hex digits msb first, letters in random case
  task automatic send_hex_digits(input logic [15:0] value, input int count);
    logic [3:0] nib;
    logic [7:0] ch;
    for (int i = 0; i < count; i++) begin
      nib = value[15 - 4 * i -: 4];
      if (nib < 4'd10) ch = 8'h30 + nib;
      else if ($urandom_range(0, 1)) ch = 8'h61 + nib - 8'd10;
      else ch = 8'h41 + nib - 8'd10;
      send_byte(ch);
    end
  endtask

  task automatic send_uesc(input logic [15:0] value);
    send_byte(CH_BSLASH);
    send_byte(CH_LOW_U);
    send_hex_digits(value, 4);
  endtask

  function automatic logic is_escape_letter(input logic [7:0] c);
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B,
      CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick_escape_letter();
    case ($urandom_range(0, 7))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_LOW_B;
      4: return CH_LOW_F;
      5: return CH_LOW_N;
      6: return CH_LOW_R;
      default: return CH_LOW_T;
    endcase
  endfunction

  function automatic logic [7:0] pick_bad_letter();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (is_escape_letter(b) || b == CH_LOW_U);
    return b;
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (hex_nibble(b) >= 0);
    return b;
  endfunction

  // code point outside the surrogate range, spread over the utf-8 lengths
  function automatic logic [15:0] pick_bmp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 'h7f));
      1: return 16'($urandom_range('h80, 'h7ff));
      2: return 16'($urandom_range('h800, 'hd7ff));
      default: return 16'($urandom_range('he000, 'hffff));
    endcase
  endfunction

  function automatic logic [15:0] pick_high();
    return 16'hd800 + 16'($urandom_range(0, 'h3ff));
  endfunction

  function automatic logic [15:0] pick_low();
    return 16'hdc00 + 16'($urandom_range(0, 'h3ff));
  endfunction

  function automatic logic [15:0] pick_not_low();
    logic [15:0] v;
    do v = 16'($urandom_range(0, 'hffff));
    while (v >= 16'hdc00 && v <= 16'hdfff);
    return v;
  endfunction

  // one content piece of a string body
  task automatic send_body_piece();
    case ($urandom_range(0, 9))
      0, 1: send_byte(pick_plain());
      2: send_byte(8'($urandom_range('h80, 'hff)));
      3: send_byte(8'($urandom_range(0, 'h1f)));
      4: begin
        send_byte(CH_BSLASH);
        send_byte(pick_escape_letter());
      end
      5: send_uesc(pick_bmp());
      6: begin
        send_uesc(pick_high());
        send_uesc(pick_low());
      end
      // lone high surrogate, then plain content or a simple escape
      7: begin
        send_uesc(pick_high());
        if ($urandom_range(0, 1)) begin
          send_byte(pick_plain());
        end else begin
          send_byte(CH_BSLASH);
          send_byte(pick_escape_letter());
        end
      end
      // lone low surrogate passes as three bytes
      8: send_uesc(pick_low());
      default: send_byte(pick_plain());
    endcase
  endtask

  // close the string, or break it in one of the ways the decoder reports
  task automatic send_string_tail();
    case ($urandom_range(0, 17))
      9: send_end();
      10: begin
        send_byte(CH_BSLASH);
        send_end();
      end
      11: begin
        send_byte(CH_BSLASH);
        send_byte(pick_bad_letter());
      end
      // bad digit or text end inside the first hex escape
      12: begin
        send_byte(CH_BSLASH);
        send_byte(CH_LOW_U);
        send_hex_digits(pick_bmp(), $urandom_range(0, 3));
        if ($urandom_range(0, 1)) send_byte(pick_non_hex());
        else send_end();
      end
      // bad digit or text end inside the low half
      13: begin
        send_uesc(pick_high());
        send_byte(CH_BSLASH);
        send_byte(CH_LOW_U);
        send_hex_digits(pick_low(), $urandom_range(0, 3));
        if ($urandom_range(0, 1)) send_byte(pick_non_hex());
        else send_end();
      end
      // low half out of range
      14: begin
        send_uesc(pick_high());
        send_uesc(pick_not_low());
      end
      // high surrogate pending at the end of the string
      15: begin
        send_uesc(pick_high());
        case ($urandom_range(0, 2))
          0: send_end();
          1: begin
            send_byte(CH_BSLASH);
            send_end();
          end
          default: send_byte(CH_QUOTE);
        endcase
      end
      default: send_byte(CH_QUOTE);
    endcase
  endtask

  // well-formed strings with random content, some broken, some noise between
  task automatic send_random_strings(input int count);
    int goal;
    int pieces;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1)) send_end();
        else send_byte(pick_plain());
      end
      send_byte(CH_QUOTE);
      pieces = $urandom_range(0, 6);
      repeat (pieces) send_body_piece();
      send_string_tail();
    end
  endtask

  // bytes and text end while waiting for a quote
  task automatic test_waiting_noise();
    tx_max_wait = 6;
    rx_max_wait = 6;
    send_byte(8'h61);
    send_end();
  endtask

  // plain extremes and the single-byte escapes b, f, n, r, t and slash
  task automatic test_plain_and_escapes();
    send_byte(CH_QUOTE);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(CH_BSLASH);
    send_byte(CH_LOW_B);
    send_byte(CH_BSLASH);
    send_byte(CH_LOW_F);
    send_byte(CH_BSLASH);
    send_byte(CH_LOW_N);
    send_byte(CH_BSLASH);
    send_byte(CH_LOW_R);
    send_byte(CH_BSLASH);
    send_byte(CH_LOW_T);
    send_byte(CH_BSLASH);
    send_byte(CH_SLASH);
    send_byte(CH_QUOTE);
  endtask

  // two-byte top and the highest surrogate pair
  task automatic test_unicode_escapes();
    send_byte(CH_QUOTE);
    send_uesc(16'h07ff);
    send_uesc(16'hdbff);
    send_uesc(16'hdfff);
    send_byte(CH_QUOTE);
  endtask

  // unsupported escape, then a pending high surrogate cut by text end
  task automatic test_error_cases();
    send_byte(CH_QUOTE);
    send_byte(CH_BSLASH);
    send_byte(8'h71);
    send_byte(CH_QUOTE);
    send_uesc(16'hd800);
    send_end();
  endtask

  task automatic test_random_no_idle();
    tx_max_wait = 0;
    rx_max_wait = 0;
    send_random_strings(120);
  endtask

  task automatic test_random_idle();
    tx_max_wait = 6;
    rx_max_wait = 6;
    send_random_strings(120);
  endtask

  // fast writer against a slow reader keeps the queue full
  task automatic test_random_slow_reader();
    tx_max_wait = 0;
    rx_max_wait = 6;
    send_random_strings(120);
  endtask

  // reader: random stall before each item
  initial begin
    int stall;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, rx_max_wait);
      repeat (stall) @(negedge clk_i) pop <= 1'b0;
      @(negedge clk_i);
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && pop && !empty) begin
      if (utf8_expect_q.size() == 0) begin
        $error("result item with no expectation waiting: kind %0d byte %0h",
               out_item_o.kind, out_item_o.out_byte);
        error_count++;
      end else begin
        exp_item = utf8_expect_q.pop_front();
        if (out_item_o.kind !== exp_item.kind) begin
          $error("kind mismatch: expected %0d, got %0d", exp_item.kind, out_item_o.kind);
          error_count++;
        end
        if (out_item_o.out_byte !== exp_item.out_byte) begin
          $error("out_byte mismatch: expected %0h, got %0h",
                 exp_item.out_byte, out_item_o.out_byte);
          error_count++;
        end
        if (out_item_o.err_num !== exp_item.err_num) begin
          $error("err_num mismatch: expected %0d, got %0d",
                 exp_item.err_num, out_item_o.err_num);
          error_count++;
        end
        if (out_item_o.last !== exp_item.last) begin
          $error("last mismatch: expected %0d, got %0d", exp_item.last, out_item_o.last);
          error_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main sequence
  initial begin
    error_count = 0;
    items_sent  = 0;
    tx_max_wait = 0;
    rx_max_wait = 0;
    dec_state   = ST_WAIT;
    hex_acc     = '0;
    hex_cnt     = '0;
    high_bits   = '0;
    rst_ni      = 1'b0;
    push        = 1'b0;
    in_item_i   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_waiting_noise();
    test_plain_and_escapes();
    test_unicode_escapes();
    test_error_cases();
    test_random_no_idle();
    test_random_idle();
    test_random_slow_reader();

    // drain, then watch for stray results
    @(negedge clk_i) push <= 1'b0;
    rx_max_wait = 0;
    while (utf8_expect_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_fifo.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
dv/json_string_unescape_utf8_tb.sv
